@@ hw/rtl/usc_pkg.sv @@
// Shared types, constants and lookup functions for the seconds-to-date converter.
package usc_pkg;

  // Reciprocal for (secs >> 4) / 225, which is secs / 3600; exact for 28-bit inputs
  localparam logic [28:0] RECIP_HOUR   = 29'd305419897;
  localparam int          HOUR_SHIFT   = 36;
  // Reciprocal for rem / 60 with rem < 3600
  localparam logic [12:0] RECIP_MIN    = 13'd4370;
  localparam int          MIN_SHIFT    = 18;
  // Reciprocal for (lh >> 3) / 3, which is lh / 24
  localparam logic [18:0] RECIP_DAY    = 19'd349526;
  localparam int          DAY_SHIFT    = 20;
  // Reciprocal for x / 1461 with x < 2^18
  localparam logic [19:0] RECIP_4Y     = 20'd734937;
  localparam int          Y4_SHIFT     = 30;
  // Reciprocal for x / 153 with x < 2^11
  localparam logic [12:0] RECIP_5MON   = 13'd6854;
  localparam int          MON_SHIFT    = 20;

  localparam logic [21:0] DAYS_TO_JDN  = 22'd2472632;
  localparam logic [10:0] DAYS_PER_4Y  = 11'd1461;
  localparam logic [11:0] SECS_PER_HR  = 12'd3600;
  localparam logic [11:0] SIXTY        = 12'd60;
  localparam logic [4:0]  HRS_PER_DAY  = 5'd24;

  // Thresholds on 4a+3 where the century count steps past 67 and 68
  localparam logic [23:0] CYCLE_68     = 24'd9934596;
  localparam logic [23:0] CYCLE_69     = 24'd10080693;

  // Century selector: century count minus 67
  typedef enum logic [1:0] {
    CYC_67 = 2'd0,
    CYC_68 = 2'd1,
    CYC_69 = 2'd2
  } cyc_sel_t;

  // Time-of-day fields carried alongside the date stages
  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
  } tod_t;

  // Beat handed from the time split to the date stages
  typedef struct packed {
    logic        valid;
    tod_t        tod;
    logic [15:0] days;
  } day_beat_t;

  // (146097 * b) / 4 for the supported century counts
  function automatic logic [21:0] cycle_base(input cyc_sel_t sel);
    logic [21:0] base;
    unique case (sel)
      CYC_67:  base = 22'd2447124;
      CYC_68:  base = 22'd2483649;
      CYC_69:  base = 22'd2520173;
      default: base = 22'd2447124;
    endcase
    return base;
  endfunction

  // (153 * m + 2) / 5: day offset of the start of each March-based month
  function automatic logic [8:0] month_base(input logic [3:0] m);
    logic [8:0] base;
    unique case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd61;
      4'd3:    base = 9'd92;
      4'd4:    base = 9'd122;
      4'd5:    base = 9'd153;
      4'd6:    base = 9'd184;
      4'd7:    base = 9'd214;
      4'd8:    base = 9'd245;
      4'd9:    base = 9'd275;
      4'd10:   base = 9'd306;
      4'd11:   base = 9'd337;
      4'd12:   base = 9'd367;
      4'd13:   base = 9'd398;
      4'd14:   base = 9'd428;
      default: base = 9'd459;
    endcase
    return base;
  endfunction

endpackage

@@ hw/rtl/usc_split.sv @@
// Four-stage split of epoch seconds into second, minute, local hour and day count.
module usc_split
  import usc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [31:0]      secs,
  input  logic signed [4:0] zone_offset,
  output day_beat_t        beat
);

  // Stage valid bits
  logic [3:0] vld;

  // Stage 1: product for the hour quotient
  logic [56:0] s1_prod;
  logic [11:0] s1_lo;

  // Stage 2: remainder within the hour, clamped local hour count
  logic [20:0] s2_hrs;
  logic [11:0] s2_hx;
  logic [22:0] s2_sum;
  logic [11:0] s2_rem;
  logic [20:0] s2_lh;

  // Stage 3: minute and day quotients
  logic [29:0] s3_minp;
  logic [37:0] s3_dayp;
  logic [11:0] s3_rem;
  logic [5:0]  s3_min;
  logic [15:0] s3_days;
  logic [4:0]  s3_lh5;

  // Stage 4: remainders
  logic [11:0] s4_m60;
  logic [4:0]  s4_d24;
  tod_t        s4_tod;
  logic [15:0] s4_days;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], in_valid};
    end
  end

  // Stage 1
  always_ff @(posedge clk) begin
    s1_prod <= 57'(secs[31:4]) * 57'(RECIP_HOUR);
    s1_lo   <= secs[11:0];
  end

  // Stage 2: apply zone offset, clamp below the epoch
  always_comb begin
    s2_hrs = s1_prod[HOUR_SHIFT +: 21];
    s2_hx  = 12'(s2_hrs) * SECS_PER_HR;
    s2_sum = $signed({2'b00, s2_hrs}) + 23'(zone_offset);
  end

  always_ff @(posedge clk) begin
    s2_rem <= s1_lo - s2_hx;
    s2_lh  <= s2_sum[22] ? '0 : s2_sum[20:0];
  end

  // Stage 3
  always_comb begin
    s3_minp = 30'(s2_rem) * 30'(RECIP_MIN);
    s3_dayp = 38'(s2_lh[20:3]) * 38'(RECIP_DAY);
  end

  always_ff @(posedge clk) begin
    s3_rem  <= s2_rem;
    s3_min  <= s3_minp[MIN_SHIFT +: 6];
    s3_days <= s3_dayp[DAY_SHIFT +: 16];
    s3_lh5  <= s2_lh[4:0];
  end

  // Stage 4
  always_comb begin
    s4_m60 = 12'(s3_min) * SIXTY;
    s4_d24 = s3_days[4:0] * HRS_PER_DAY;
  end

  always_ff @(posedge clk) begin
    s4_tod.sec  <= s3_rem[5:0] - s4_m60[5:0];
    s4_tod.min  <= s3_min;
    s4_tod.hour <= s3_lh5 - s4_d24;
    s4_days     <= s3_days;
  end

  assign beat.valid = vld[3];
  assign beat.tod   = s4_tod;
  assign beat.days  = s4_days;

endmodule

@@ hw/rtl/usc_date.sv @@
// Five-stage day-number to Gregorian date conversion.
module usc_date
  import usc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  day_beat_t  beat,
  output logic       out_valid,
  output tod_t       out_tod,
  output logic [4:0] out_mday,
  output logic [3:0] out_mon,
  output logic [7:0] out_year
);

  logic [4:0] vld;

  // Stage 5: century count by threshold, day within the century
  logic [21:0] s5_a;
  logic [23:0] s5_v;
  cyc_sel_t    s5_sel;
  logic [21:0] s5_cw;
  tod_t        r5_tod;
  cyc_sel_t    r5_sel;
  logic [15:0] r5_c;

  // Stage 6: year within the century
  logic [37:0] s6_p;
  tod_t        r6_tod;
  cyc_sel_t    r6_sel;
  logic [15:0] r6_c;
  logic [6:0]  r6_d;

  // Stage 7: day within the March-based year
  logic [17:0] s7_q;
  logic [15:0] s7_e;
  tod_t        r7_tod;
  cyc_sel_t    r7_sel;
  logic [6:0]  r7_d;
  logic [8:0]  r7_e;

  // Stage 8: March-based month
  logic [10:0] s8_x;
  logic [23:0] s8_p;
  tod_t        r8_tod;
  cyc_sel_t    r8_sel;
  logic [6:0]  r8_d;
  logic [8:0]  r8_e;
  logic [3:0]  r8_m;

  // Stage 9: final fields
  logic       s9_wrap;
  logic [8:0] s9_mday;
  logic [7:0] s9_cent;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], beat.valid};
    end
  end

  // Stage 5
  always_comb begin
    s5_a = 22'(beat.days) + DAYS_TO_JDN;
    s5_v = {s5_a, 2'b11};
    priority if (s5_v >= CYCLE_69) begin
      s5_sel = CYC_69;
    end else if (s5_v >= CYCLE_68) begin
      s5_sel = CYC_68;
    end else begin
      s5_sel = CYC_67;
    end
    s5_cw = s5_a - cycle_base(s5_sel);
  end

  always_ff @(posedge clk) begin
    r5_tod <= beat.tod;
    r5_sel <= s5_sel;
    r5_c   <= s5_cw[15:0];
  end

  // Stage 6
  assign s6_p = 38'({r5_c, 2'b11}) * 38'(RECIP_4Y);

  always_ff @(posedge clk) begin
    r6_tod <= r5_tod;
    r6_sel <= r5_sel;
    r6_c   <= r5_c;
    r6_d   <= s6_p[Y4_SHIFT +: 7];
  end

  // Stage 7
  always_comb begin
    s7_q = 18'(r6_d) * 18'(DAYS_PER_4Y);
    s7_e = r6_c - 16'(s7_q[17:2]);
  end

  always_ff @(posedge clk) begin
    r7_tod <= r6_tod;
    r7_sel <= r6_sel;
    r7_d   <= r6_d;
    r7_e   <= s7_e[8:0];
  end

  // Stage 8
  always_comb begin
    s8_x = 11'(r7_e) * 11'd5 + 11'd2;
    s8_p = 24'(s8_x) * 24'(RECIP_5MON);
  end

  always_ff @(posedge clk) begin
    r8_tod <= r7_tod;
    r8_sel <= r7_sel;
    r8_d   <= r7_d;
    r8_e   <= r7_e;
    r8_m   <= s8_p[MON_SHIFT +: 4];
  end

  // Stage 9: Jan and Feb wrap into the next year
  always_comb begin
    s9_wrap = (r8_m >= 4'd10);
    s9_mday = r8_e - month_base(r8_m) + 9'd1;
    s9_cent = 8'(r8_sel) * 8'd100;
  end

  always_ff @(posedge clk) begin
    out_tod  <= r8_tod;
    out_mday <= s9_mday[4:0];
    out_mon  <= s9_wrap ? (r8_m - 4'd10) : (r8_m + 4'd2);
    out_year <= s9_cent + 8'(r8_d) + 8'(s9_wrap);
  end

  assign out_valid = vld[4];

endmodule

@@ hw/rtl/unix_seconds_to_calendar_date.sv @@
// Top level: Unix seconds to local calendar date, nine-stage pipeline.
// Throughput: one item per cycle; busy is always low, the pipeline never holds.
// Results cannot be stalled by the receiver; one done beat per accepted start.
// Reset (rst, synchronous) clears all valid bits and sets the zone offset to 0.
module unix_seconds_to_calendar_date
  import usc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] epoch_seconds,
  input  logic        cfg_write,
  input  logic [4:0]  cfg_data,
  output logic        done,
  output logic [5:0]  second_of_minute,
  output logic [5:0]  minute_of_hour,
  output logic [4:0]  hour_of_day,
  output logic [4:0]  day_of_month,
  output logic [3:0]  month_index,
  output logic [7:0]  years_since_1900
);

  logic signed [4:0] zone_offset_hours;
  day_beat_t         day_beat;
  tod_t              tod;

  // Zone offset register
  always_ff @(posedge clk) begin
    if (rst) begin
      zone_offset_hours <= '0;
    end else if (cfg_write) begin
      zone_offset_hours <= $signed(cfg_data);
    end
  end

  assign busy = 1'b0;

  usc_split u_split (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (start && !busy),
    .secs        (epoch_seconds),
    .zone_offset (zone_offset_hours),
    .beat        (day_beat)
  );

  usc_date u_date (
    .clk       (clk),
    .rst       (rst),
    .beat      (day_beat),
    .out_valid (done),
    .out_tod   (tod),
    .out_mday  (day_of_month),
    .out_mon   (month_index),
    .out_year  (years_since_1900)
  );

  assign second_of_minute = tod.sec;
  assign minute_of_hour   = tod.min;
  assign hour_of_day      = tod.hour;

endmodule

@@ test/unix_seconds_to_calendar_date_test.sv @@
// Testbench for the Unix-seconds to calendar-date converter with a built-in date predictor.
`timescale 1ns / 1ps

module unix_seconds_to_calendar_date_test;

  localparam int HALF_PERIOD   = 10;
  localparam int PIPE_LATENCY  = 9;
  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_ITEMS  = 1150;
  localparam int ZONE_PHASES   = 10;
  localparam int SECS_PER_DAY  = 86400;

  // One calendar result as the block reports it
  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [4:0] mday;
    logic [3:0] mon;
    logic [7:0] year;
  } cal_date_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] epoch_seconds;
  logic        cfg_write;
  logic [4:0]  cfg_data;
  logic        done;
  logic [5:0]  second_of_minute;
  logic [5:0]  minute_of_hour;
  logic [4:0]  hour_of_day;
  logic [4:0]  day_of_month;
  logic [3:0]  month_index;
  logic [7:0]  years_since_1900;

  cal_date_t expected_dates[$];
  int        zone_hours;
  int        mismatch_count;
  int        idle_cycles;

  unix_seconds_to_calendar_date DUT (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .epoch_seconds    (epoch_seconds),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .done             (done),
    .second_of_minute (second_of_minute),
    .minute_of_hour   (minute_of_hour),
    .hour_of_day      (hour_of_day),
    .day_of_month     (day_of_month),
    .month_index      (month_index),
    .years_since_1900 (years_since_1900)
  );

  // Clock
  always begin
    clk = 1'b1;
    #HALF_PERIOD;
    clk = 1'b0;
    #HALF_PERIOD;
  end

  // Date predictor: split into h/m/s, apply the zone, then day number to
  // Gregorian date through the Julian-day-number route
  function automatic cal_date_t predict_date(input logic [31:0] secs, input int zone);
    cal_date_t r;
    longint    mins, hrs, lh, days, a, b, c, d, e, m, mday, wrap, mon, year;
    mins = longint'(secs) / 60;
    hrs  = mins / 60 + zone;
    lh   = (hrs < 0) ? 0 : hrs;   // local time before the epoch clamps to hour zero
    days = lh / 24;
    a    = days + 2472632;
    b    = (4 * a + 3) / 146097;
    c    = a - (146097 * b) / 4;
    d    = (4 * c + 3) / 1461;
    e    = c - (1461 * d) / 4;
    m    = (5 * e + 2) / 153;
    mday = e - (153 * m + 2) / 5 + 1;
    wrap = m / 10;
    mon  = m + 2 - 12 * wrap;
    year = 100 * b + d + wrap - 6700;
    r.sec  = 6'(longint'(secs) % 60);
    r.min  = 6'(mins % 60);
    r.hour = 5'(lh % 24);
    r.mday = 5'(mday);
    r.mon  = 4'(mon);
    r.year = 8'(year);
    return r;
  endfunction

  // Input side: predict each accepted beat, track register writes
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy)
        expected_dates.push_back(predict_date(epoch_seconds, zone_hours));
      if (cfg_write)
        zone_hours = int'($signed(cfg_data));
    end
  end

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Result side: every done beat must match the oldest prediction
  always @(posedge clk) begin
    cal_date_t want;
    if (!rst && done) begin
      if (expected_dates.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result beat, expected none, actual %0d-%0d-%0d %0d:%0d:%0d",
                 $time, years_since_1900, month_index, day_of_month,
                 hour_of_day, minute_of_hour, second_of_minute);
      end else begin
        want = expected_dates.pop_front();
        report_field("second_of_minute", want.sec, second_of_minute);
        report_field("minute_of_hour", want.min, minute_of_hour);
        report_field("hour_of_day", want.hour, hour_of_day);
        report_field("day_of_month", want.mday, day_of_month);
        report_field("month_index", want.mon, month_index);
        report_field("years_since_1900", want.year, years_since_1900);
      end
    end
  end

  // Watchdog on cycles with no accepted beat on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || done)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
      $display("unix_seconds_to_calendar_date_test NOT OK");
      $finish;
    end
  end

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap(input bit burst);
    int roll;
    roll = $urandom_range(0, 99);
    if (burst || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Send one timestamp beat; called and left at a falling edge
  task automatic send_timestamp(input logic [31:0] secs, input int gap);
    start         <= 1'b1;
    epoch_seconds <= secs;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    if (gap > 0) begin
      start         <= 1'b0;
      epoch_seconds <= $urandom;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Let the pipeline drain, then rewrite the zone offset
  task automatic set_zone_offset(input logic [4:0] zone);
    start <= 1'b0;
    while (expected_dates.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 3) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= zone;
    @(negedge clk);
    cfg_write <= 1'b0;
    cfg_data  <= $urandom;
  endtask

  // Field extremes and calendar corners at the reset offset of zero
  task automatic test_field_extremes();
    logic [31:0] corners[12];
    corners = '{32'd0, 32'd59, 32'd3599, 32'd86399, 32'd946684799, 32'd951782400,
                32'd951868800, 32'd4107456000, 32'd4107542400, 32'h7FFFFFFF,
                32'hAAAAAAAA, 32'hFFFFFFFF};
    foreach (corners[i])
      send_timestamp(corners[i], pick_gap(1'b0));
  endtask

  // Offset extremes, including the clamp before the epoch and wrap past the top
  task automatic test_zone_extremes();
    logic [4:0]  zones[4];
    logic [31:0] probes[3];
    zones  = '{5'b10000, 5'b10100, 5'd14, 5'd15};
    probes = '{32'd0, 32'd7199, 32'hFFFFFFFF};
    foreach (zones[z]) begin
      set_zone_offset(zones[z]);
      foreach (probes[p])
        send_timestamp(probes[p], pick_gap(1'b0));
    end
  endtask

  // Random timestamps over several offsets, the first two at the extremes, the rest random
  task automatic test_random_timestamps();
    int          per_phase;
    int          roll;
    bit          burst;
    longint      t;
    logic [31:0] secs;
    per_phase = RANDOM_ITEMS / ZONE_PHASES;
    for (int ph = 0; ph < ZONE_PHASES; ph++) begin
      set_zone_offset((ph == 0) ? 5'b10000 : (ph == 1) ? 5'd15 : 5'($urandom_range(0, 31)));
      burst = (ph % 3 == 0);
      for (int i = 0; i < per_phase; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
          secs = $urandom;
        end else if (roll < 85) begin
          // near a local midnight, where day, month and year roll over
          t = longint'($urandom_range(0, 49710)) * SECS_PER_DAY - zone_hours * 3600
              + $urandom_range(0, 20) - 10;
          secs = 32'(t);
        end else begin
          // first hours after the epoch, where negative offsets clamp
          secs = $urandom_range(0, 2 * SECS_PER_DAY);
        end
        send_timestamp(secs, pick_gap(burst));
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    epoch_seconds = '0;
    cfg_write     = 1'b0;
    cfg_data      = '0;
    zone_hours    = 0;
    mismatch_count = 0;
    idle_cycles   = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_zone_extremes();
    test_random_timestamps();

    start <= 1'b0;
    while (expected_dates.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 10) @(negedge clk);
    if (mismatch_count == 0)
      $display("unix_seconds_to_calendar_date_test OK");
    else
      $display("unix_seconds_to_calendar_date_test NOT OK");
    $finish;
  end

endmodule
